FILE: design/tacs_pkg.sv
// tacs_pkg: opcode, status and stack constants plus item and result types
// for the tiny accumulator cpu step block; no dependencies
`default_nettype none

package tacs_pkg;

	localparam logic [7:0] OP_NOP  = 8'd0;
	localparam logic [7:0] OP_LDAI = 8'd1;
	localparam logic [7:0] OP_LDXI = 8'd2;
	localparam logic [7:0] OP_LDYI = 8'd3;
	localparam logic [7:0] OP_LDAM = 8'd4;
	localparam logic [7:0] OP_STAM = 8'd5;
	localparam logic [7:0] OP_ADDI = 8'd6;
	localparam logic [7:0] OP_SUBI = 8'd7;
	localparam logic [7:0] OP_CMPI = 8'd8;
	localparam logic [7:0] OP_JMP  = 8'd9;
	localparam logic [7:0] OP_JZ   = 8'd10;
	localparam logic [7:0] OP_JNZ  = 8'd11;
	localparam logic [7:0] OP_CALL = 8'd12;
	localparam logic [7:0] OP_RET  = 8'd13;
	localparam logic [7:0] OP_SYS  = 8'd14;
	localparam logic [7:0] OP_HLT  = 8'd15;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_ILLEGAL = 2'd1;
	localparam logic [1:0] ST_HALTED  = 2'd2;

	localparam logic [15:0] SP_INIT = 16'hFFFE;

	// result queue
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = 2;
	localparam int OQ_CW    = 3;

	typedef struct packed {
		logic [7:0]  mode;
		logic [7:0]  imm;
		logic [15:0] target;
		logic [7:0]  load_byte;
		logic [15:0] popped_addr;
		logic [23:0] sys_result;
	} item_t;

	typedef struct packed {
		logic        write_valid;
		logic [15:0] write_addr;
		logic [7:0]  write_byte;
		logic [15:0] pc_out;
		logic [15:0] sp_out;
		logic [7:0]  acc_out;
		logic [7:0]  x_out;
		logic [7:0]  y_out;
		logic [1:0]  flags_out;
		logic [1:0]  status;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        wr;
		logic [15:0] start_pc;
	} cfg_t;

	typedef struct packed {
		logic    push;
		logic    two;
		result_t res0;
		result_t res1;
	} push_t;

endpackage

`default_nettype wire

FILE: design/tacs_exec.sv
// tacs_exec: architectural registers and combinational instruction execute
// depends on tacs_pkg
`default_nettype none

module tacs_exec (
	input  wire               clk,
	input  wire               arst_n,
	input  tacs_pkg::cfg_t    cfg,
	input  wire               fire,
	input  tacs_pkg::item_t   item,
	output tacs_pkg::push_t   pq
);

	logic [7:0]  acc_q, x_q, y_q;
	logic        zf_q, cf_q, stop_q;
	logic [15:0] pc_q, sp_q;

	logic [7:0]  acc_n, x_n, y_n;
	logic        zf_n, cf_n, stop_n;
	logic [15:0] pc_n, sp_n;
	logic        wv0, two;
	logic [15:0] wa0, wa1;
	logic [7:0]  wb0, wb1;
	logic [1:0]  st;
	logic [8:0]  sum;
	logic [15:0] pc1, pc2, pc3, ret;

	always_comb begin
		acc_n = acc_q;
		x_n = x_q;
		y_n = y_q;
		zf_n = zf_q;
		cf_n = cf_q;
		stop_n = stop_q;
		pc_n = pc_q;
		sp_n = sp_q;
		wv0 = 1'b0;
		wa0 = '0;
		wb0 = '0;
		wa1 = '0;
		wb1 = '0;
		two = 1'b0;
		st = tacs_pkg::ST_OK;
		pc1 = pc_q + 16'd1;
		pc2 = pc_q + 16'd2;
		pc3 = pc_q + 16'd3;
		ret = pc3;
		sum = {1'b0, acc_q} + {1'b0, item.imm};
		if (stop_q) begin
			st = tacs_pkg::ST_HALTED;
		end else begin
			unique case (item.mode)
				tacs_pkg::OP_NOP: pc_n = pc1;
				tacs_pkg::OP_LDAI: begin
					acc_n = item.imm;
					zf_n = (item.imm == 8'd0);
					pc_n = pc2;
				end
				tacs_pkg::OP_LDXI: begin
					x_n = item.imm;
					pc_n = pc2;
				end
				tacs_pkg::OP_LDYI: begin
					y_n = item.imm;
					pc_n = pc2;
				end
				tacs_pkg::OP_LDAM: begin
					acc_n = item.load_byte;
					zf_n = (item.load_byte == 8'd0);
					pc_n = pc3;
				end
				tacs_pkg::OP_STAM: begin
					wv0 = 1'b1;
					wa0 = item.target;
					wb0 = acc_q;
					pc_n = pc3;
				end
				tacs_pkg::OP_ADDI: begin
					acc_n = sum[7:0];
					cf_n = sum[8];
					zf_n = (sum[7:0] == 8'd0);
					pc_n = pc2;
				end
				tacs_pkg::OP_SUBI: begin
					acc_n = acc_q - item.imm;
					cf_n = 1'b0;
					zf_n = (acc_q == item.imm);
					pc_n = pc2;
				end
				tacs_pkg::OP_CMPI: begin
					zf_n = (acc_q == item.imm);
					pc_n = pc2;
				end
				tacs_pkg::OP_JMP: pc_n = item.target;
				tacs_pkg::OP_JZ: pc_n = zf_q ? item.target : pc3;
				tacs_pkg::OP_JNZ: pc_n = zf_q ? pc3 : item.target;
				tacs_pkg::OP_CALL: begin
					// low byte of return address at sp, high byte at sp-1
					two = 1'b1;
					wv0 = 1'b1;
					wa0 = sp_q;
					wb0 = ret[7:0];
					wa1 = sp_q - 16'd1;
					wb1 = ret[15:8];
					sp_n = sp_q - 16'd2;
					pc_n = item.target;
				end
				tacs_pkg::OP_RET: begin
					sp_n = sp_q + 16'd2;
					pc_n = item.popped_addr;
				end
				tacs_pkg::OP_SYS: begin
					acc_n = item.sys_result[7:0];
					x_n = item.sys_result[15:8];
					y_n = item.sys_result[23:16];
					zf_n = (item.sys_result[7:0] == 8'd0);
					pc_n = pc_q + 16'd6;
				end
				tacs_pkg::OP_HLT: begin
					stop_n = 1'b1;
					pc_n = pc1;
				end
				default: begin
					st = tacs_pkg::ST_ILLEGAL;
					pc_n = pc1;
				end
			endcase
		end

		pq.push = fire;
		pq.two = two;
		pq.res0.write_valid = wv0;
		pq.res0.write_addr = wa0;
		pq.res0.write_byte = wb0;
		pq.res0.pc_out = pc_n;
		pq.res0.sp_out = sp_n;
		pq.res0.acc_out = acc_n;
		pq.res0.x_out = x_n;
		pq.res0.y_out = y_n;
		pq.res0.flags_out = {cf_n, zf_n};
		pq.res0.status = st;
		pq.res0.last = ~two;
		pq.res1 = pq.res0;
		pq.res1.write_valid = 1'b1;
		pq.res1.write_addr = wa1;
		pq.res1.write_byte = wb1;
		pq.res1.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			x_q <= '0;
			y_q <= '0;
			zf_q <= 1'b0;
			cf_q <= 1'b0;
			stop_q <= 1'b0;
			pc_q <= '0;
			sp_q <= tacs_pkg::SP_INIT;
		end else if (cfg.wr) begin
			// start pc write restarts the machine
			acc_q <= '0;
			x_q <= '0;
			y_q <= '0;
			zf_q <= 1'b0;
			cf_q <= 1'b0;
			stop_q <= 1'b0;
			pc_q <= cfg.start_pc;
			sp_q <= tacs_pkg::SP_INIT;
		end else if (fire) begin
			acc_q <= acc_n;
			x_q <= x_n;
			y_q <= y_n;
			zf_q <= zf_n;
			cf_q <= cf_n;
			stop_q <= stop_n;
			pc_q <= pc_n;
			sp_q <= sp_n;
		end
	end

endmodule

`default_nettype wire

FILE: design/tacs_outq.sv
// tacs_outq: small result queue, takes one or two results per cycle and
// hands out one; depends on tacs_pkg
`default_nettype none

module tacs_outq (
	input  wire                clk,
	input  wire                arst_n,
	input  tacs_pkg::push_t    pq,
	input  wire                pop,
	output logic               not_empty,
	output logic               room,
	output tacs_pkg::result_t  head
);

	tacs_pkg::result_t mem_q [tacs_pkg::OQ_DEPTH];
	logic [tacs_pkg::OQ_PW-1:0] wr_q, rd_q, wr_p1;
	logic [tacs_pkg::OQ_CW-1:0] cnt_q, n_push;

	assign wr_p1 = wr_q + tacs_pkg::OQ_PW'(1);
	assign n_push = pq.push ? (pq.two ? tacs_pkg::OQ_CW'(2) : tacs_pkg::OQ_CW'(1))
		: '0;
	assign not_empty = (cnt_q != '0);
	// space for a two-result item, from registered count only
	assign room = (cnt_q <= tacs_pkg::OQ_CW'(tacs_pkg::OQ_DEPTH - 2));
	assign head = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (pq.push) begin
			mem_q[wr_q] <= pq.res0;
			if (pq.two) begin
				mem_q[wr_p1] <= pq.res1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + n_push[tacs_pkg::OQ_PW-1:0];
			if (pop) begin
				rd_q <= rd_q + tacs_pkg::OQ_PW'(1);
			end
			cnt_q <= cnt_q + n_push - (pop ? tacs_pkg::OQ_CW'(1) : '0);
		end
	end

endmodule

`default_nettype wire

FILE: design/tiny_accumulator_cpu_step.sv
// tiny_accumulator_cpu_step: top level, input register, execute and result queue
// depends on tacs_pkg, tacs_exec, tacs_outq
//
// channel | handshake              | moves
// in      | in_valid / in_stall    | one fetched instruction item
// out     | out_valid / out_stall  | one result item (write + register snapshot)
// cfg     | cfg_valid / cfg_ready  | start_pc value, restarts the machine
//
// one item accepted per cycle while in_stall is low; a result passes the input register, then the result queue
// call gives two results from one execute step through the 4-entry result queue
// in_stall rises when an item waits in the input register and the queue holds
// more than two results; it never depends on out_stall in the same cycle
// arst_n clears all control state; pc 0, sp 0xfffe
`default_nettype none

module tiny_accumulator_cpu_step (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [7:0]  mode,
	input  wire  [7:0]  imm,
	input  wire  [15:0] target,
	input  wire  [7:0]  load_byte,
	input  wire  [15:0] popped_addr,
	input  wire  [23:0] sys_result,
	output logic        out_valid,
	input  wire         out_stall,
	output logic        write_valid,
	output logic [15:0] write_addr,
	output logic [7:0]  write_byte,
	output logic [15:0] pc_out,
	output logic [15:0] sp_out,
	output logic [7:0]  acc_out,
	output logic [7:0]  x_out,
	output logic [7:0]  y_out,
	output logic [1:0]  flags_out,
	output logic [1:0]  status,
	output logic        last,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [15:0] cfg_data
);

	logic              valid_s1;
	tacs_pkg::item_t   item_s1;
	tacs_pkg::cfg_t    cfg;
	tacs_pkg::push_t   pq;
	tacs_pkg::result_t head;
	logic              room, fire, accept, pop;

	assign cfg_ready = 1'b1;
	assign cfg.wr = cfg_valid;
	assign cfg.start_pc = cfg_data;

	assign fire = valid_s1 & room;
	assign in_stall = valid_s1 & ~room;
	assign accept = in_valid & ~in_stall;
	assign pop = out_valid & ~out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.mode <= mode;
			item_s1.imm <= imm;
			item_s1.target <= target;
			item_s1.load_byte <= load_byte;
			item_s1.popped_addr <= popped_addr;
			item_s1.sys_result <= sys_result;
		end
	end

	tacs_exec u_exec (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.fire   (fire),
		.item   (item_s1),
		.pq     (pq)
	);

	tacs_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.pq        (pq),
		.pop       (pop),
		.not_empty (out_valid),
		.room      (room),
		.head      (head)
	);

	assign write_valid = head.write_valid;
	assign write_addr = head.write_addr;
	assign write_byte = head.write_byte;
	assign pc_out = head.pc_out;
	assign sp_out = head.sp_out;
	assign acc_out = head.acc_out;
	assign x_out = head.x_out;
	assign y_out = head.y_out;
	assign flags_out = head.flags_out;
	assign status = head.status;
	assign last = head.last;

endmodule

`default_nettype wire

FILE: tb/tiny_accumulator_cpu_step_tb.sv
// tiny_accumulator_cpu_step_tb: self-checking bench for the accumulator cpu step block
// drives fetched instruction items, predicts write and register snapshot results
// depends on tacs_pkg and tiny_accumulator_cpu_step
`default_nettype none

module tiny_accumulator_cpu_step_tb;

	localparam int HOLD_CYCLES = 250;
	localparam int RUN_LIMIT   = 5000000;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [7:0]  mode        = '0;
	logic [7:0]  imm         = '0;
	logic [15:0] target      = '0;
	logic [7:0]  load_byte   = '0;
	logic [15:0] popped_addr = '0;
	logic [23:0] sys_result  = '0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic        write_valid;
	logic [15:0] write_addr;
	logic [7:0]  write_byte;
	logic [15:0] pc_out;
	logic [15:0] sp_out;
	logic [7:0]  acc_out;
	logic [7:0]  x_out;
	logic [7:0]  y_out;
	logic [1:0]  flags_out;
	logic [1:0]  status;
	logic        last;
	logic        cfg_valid   = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data    = '0;

	// machine copy kept by the bench
	logic [7:0]  cpu_acc, cpu_x, cpu_y;
	logic [1:0]  cpu_flags;
	logic [15:0] cpu_pc, cpu_sp;
	logic        cpu_halted;

	tacs_pkg::result_t due_results[$];
	int      mismatch_count = 0;
	bit      quiet = 1'b0;
	bit      tx_gaps = 1'b1;
	bit      long_hold = 1'b0;

	tiny_accumulator_cpu_step uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.imm         (imm),
		.target      (target),
		.load_byte   (load_byte),
		.popped_addr (popped_addr),
		.sys_result  (sys_result),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.write_valid (write_valid),
		.write_addr  (write_addr),
		.write_byte  (write_byte),
		.pc_out      (pc_out),
		.sp_out      (sp_out),
		.acc_out     (acc_out),
		.x_out       (x_out),
		.y_out       (y_out),
		.flags_out   (flags_out),
		.status      (status),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#RUN_LIMIT;
		$display("tiny_accumulator_cpu_step_tb: errors");
		$finish;
	end

	function automatic void restart_machine(input logic [15:0] pc0);
		cpu_acc = '0;
		cpu_x = '0;
		cpu_y = '0;
		cpu_flags = '0;
		cpu_pc = pc0;
		cpu_sp = tacs_pkg::SP_INIT;
		cpu_halted = 1'b0;
	endfunction

	function automatic tacs_pkg::result_t with_snapshot(input tacs_pkg::result_t r);
		tacs_pkg::result_t s;
		s = r;
		s.pc_out = cpu_pc;
		s.sp_out = cpu_sp;
		s.acc_out = cpu_acc;
		s.x_out = cpu_x;
		s.y_out = cpu_y;
		s.flags_out = cpu_flags;
		return s;
	endfunction

	function automatic void execute_step(input tacs_pkg::item_t it);
		tacs_pkg::result_t r;
		tacs_pkg::result_t r_lo;
		logic [8:0]  sum;
		logic [15:0] ret_addr;
		logic [15:0] sp0;
		r = '0;
		r.status = tacs_pkg::ST_OK;
		r.last = 1'b1;
		if (cpu_halted) begin
			r.status = tacs_pkg::ST_HALTED;
			due_results.push_back(with_snapshot(r));
			return;
		end
		case (it.mode)
			tacs_pkg::OP_NOP: cpu_pc = cpu_pc + 16'd1;
			tacs_pkg::OP_LDAI: begin
				cpu_acc = it.imm;
				cpu_flags[0] = (cpu_acc == 8'd0);
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_LDXI: begin
				cpu_x = it.imm;
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_LDYI: begin
				cpu_y = it.imm;
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_LDAM: begin
				cpu_acc = it.load_byte;
				cpu_flags[0] = (cpu_acc == 8'd0);
				cpu_pc = cpu_pc + 16'd3;
			end
			tacs_pkg::OP_STAM: begin
				cpu_pc = cpu_pc + 16'd3;
				r.write_valid = 1'b1;
				r.write_addr = it.target;
				r.write_byte = cpu_acc;
			end
			tacs_pkg::OP_ADDI: begin
				sum = {1'b0, cpu_acc} + {1'b0, it.imm};
				cpu_flags[1] = sum[8];
				cpu_acc = sum[7:0];
				cpu_flags[0] = (cpu_acc == 8'd0);
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_SUBI: begin
				cpu_flags[1] = 1'b0;
				cpu_acc = cpu_acc - it.imm;
				cpu_flags[0] = (cpu_acc == 8'd0);
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_CMPI: begin
				cpu_flags[0] = (cpu_acc == it.imm);
				cpu_pc = cpu_pc + 16'd2;
			end
			tacs_pkg::OP_JMP: cpu_pc = it.target;
			tacs_pkg::OP_JZ: cpu_pc = cpu_flags[0] ? it.target : cpu_pc + 16'd3;
			tacs_pkg::OP_JNZ: cpu_pc = cpu_flags[0] ? cpu_pc + 16'd3 : it.target;
			tacs_pkg::OP_CALL: begin
				ret_addr = cpu_pc + 16'd3;
				sp0 = cpu_sp;
				cpu_sp = sp0 - 16'd2;
				cpu_pc = it.target;
				r_lo = r;
				r_lo.write_valid = 1'b1;
				r_lo.write_addr = sp0;
				r_lo.write_byte = ret_addr[7:0];
				r_lo.last = 1'b0;
				due_results.push_back(with_snapshot(r_lo));
				r.write_valid = 1'b1;
				r.write_addr = sp0 - 16'd1;
				r.write_byte = ret_addr[15:8];
			end
			tacs_pkg::OP_RET: begin
				cpu_sp = cpu_sp + 16'd2;
				cpu_pc = it.popped_addr;
			end
			tacs_pkg::OP_SYS: begin
				cpu_acc = it.sys_result[7:0];
				cpu_x = it.sys_result[15:8];
				cpu_y = it.sys_result[23:16];
				cpu_flags[0] = (cpu_acc == 8'd0);
				cpu_pc = cpu_pc + 16'd6;
			end
			tacs_pkg::OP_HLT: begin
				cpu_halted = 1'b1;
				cpu_pc = cpu_pc + 16'd1;
			end
			default: begin
				cpu_pc = cpu_pc + 16'd1;
				r.status = tacs_pkg::ST_ILLEGAL;
			end
		endcase
		due_results.push_back(with_snapshot(r));
	endfunction

	function automatic tacs_pkg::item_t make_item(input logic [7:0] op, input logic [7:0] b,
			input logic [15:0] addr, input logic [7:0] lb, input logic [15:0] ra,
			input logic [23:0] sr);
		tacs_pkg::item_t it;
		it.mode = op;
		it.imm = b;
		it.target = addr;
		it.load_byte = lb;
		it.popped_addr = ra;
		it.sys_result = sr;
		return it;
	endfunction

	function automatic tacs_pkg::item_t random_item();
		tacs_pkg::item_t it;
		int unsigned     pick;
		pick = $urandom_range(0, 99);
		if (pick == 0)
			it.mode = tacs_pkg::OP_HLT;
		else if (pick < 8)
			it.mode = 8'($urandom_range(16, 255));
		else
			it.mode = 8'($urandom_range(0, 14));
		it.imm = 8'($urandom);
		it.target = 16'($urandom);
		it.load_byte = 8'($urandom);
		it.popped_addr = 16'($urandom);
		it.sys_result = 24'($urandom);
		return it;
	endfunction

	function automatic string result_text(input tacs_pkg::result_t r);
		return $sformatf("wv=%0b wa=%h wb=%h pc=%h sp=%h a=%h x=%h y=%h f=%b st=%0d last=%0b",
			r.write_valid, r.write_addr, r.write_byte, r.pc_out, r.sp_out,
			r.acc_out, r.x_out, r.y_out, r.flags_out, r.status, r.last);
	endfunction

	task automatic send_item(input tacs_pkg::item_t it);
		int gap;
		if (!quiet && tx_gaps && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 18);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= it.mode;
		imm <= it.imm;
		target <= it.target;
		load_byte <= it.load_byte;
		popped_addr <= it.popped_addr;
		sys_result <= it.sys_result;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		execute_step(it);
	endtask

	task automatic write_start_pc(input logic [15:0] pc0);
		in_valid <= 1'b0;
		@(posedge clk);
		while (due_results.size() != 0) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= pc0;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		restart_machine(pc0);
		cfg_valid <= 1'b0;
	endtask

	// pc counts up from zero before any write of start_pc
	task automatic test_reset_state();
		send_item(make_item(tacs_pkg::OP_NOP, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_LDXI, 8'h5a, 16'h0000, 8'h00, 16'h0000, 24'h0));
	endtask

	task automatic test_directed();
		write_start_pc(16'hFFFE);
		send_item(make_item(tacs_pkg::OP_NOP, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 24'hFFFFFF));
		send_item(make_item(tacs_pkg::OP_LDAI, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_LDXI, 8'hFF, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_LDYI, 8'hFF, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_ADDI, 8'hFF, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_ADDI, 8'h01, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_SUBI, 8'h01, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CMPI, 8'hFF, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CMPI, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_JZ, 8'h00, 16'h1234, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_JNZ, 8'h00, 16'h1234, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CMPI, 8'hFF, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_JZ, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_LDAM, 8'h00, 16'h8000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_LDAM, 8'h00, 16'h8000, 8'hFF, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_STAM, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_STAM, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CALL, 8'h00, 16'hFFFE, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_RET, 8'h00, 16'h0000, 8'h00, 16'hFFFF, 24'h0));
		// stack pointer wraps past the top and back
		send_item(make_item(tacs_pkg::OP_RET, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CALL, 8'h00, 16'hABCD, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_SYS, 8'hFF, 16'hFFFF, 8'h00, 16'h0000, 24'hFFFFFF));
		send_item(make_item(tacs_pkg::OP_SYS, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'hFF0000));
		send_item(make_item(8'd16, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(8'hFF, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_HLT, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_NOP, 8'h00, 16'h0000, 8'h00, 16'h0000, 24'h0));
		send_item(make_item(tacs_pkg::OP_CALL, 8'h00, 16'h4000, 8'h00, 16'h0000, 24'h0));
		// start_pc write brings a halted machine back
		write_start_pc(16'h0000);
		send_item(make_item(tacs_pkg::OP_LDXI, 8'h01, 16'h0000, 8'h00, 16'h0000, 24'h0));
	endtask

	task automatic test_random_programs();
		logic [15:0] pc0;
		for (int ph = 0; ph < 10; ph++) begin
			if (ph == 0)
				pc0 = 16'h0000;
			else if (ph == 1)
				pc0 = 16'hFFFF;
			else
				pc0 = 16'($urandom);
			write_start_pc(pc0);
			repeat (140) send_item(random_item());
		end
	endtask

	task automatic test_backpressure();
		write_start_pc(16'h2000);
		tx_gaps = 1'b0;
		long_hold = 1'b1;
		repeat (40) send_item(random_item());
		tx_gaps = 1'b1;
	endtask

	task automatic test_steady_flow();
		quiet = 1'b1;
		write_start_pc(16'($urandom));
		repeat (150) send_item(random_item());
	endtask

	initial begin : rx_side
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				out_stall <= 1'b0;
				long_hold = 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				n = $urandom_range(1, 18);
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		tacs_pkg::result_t got;
		tacs_pkg::result_t want;
		if (arst_n && out_valid && !out_stall) begin
			got = '{write_valid, write_addr, write_byte, pc_out, sp_out, acc_out,
				x_out, y_out, flags_out, status, last};
			if (due_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: %s", result_text(got));
			end else begin
				want = due_results.pop_front();
				if (got.write_valid !== want.write_valid || got.write_addr !== want.write_addr ||
						got.write_byte !== want.write_byte || got.pc_out !== want.pc_out ||
						got.sp_out !== want.sp_out || got.acc_out !== want.acc_out ||
						got.x_out !== want.x_out || got.y_out !== want.y_out ||
						got.flags_out !== want.flags_out || got.status !== want.status ||
						got.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch\n  expected %s\n  actual   %s",
							result_text(want), result_text(got));
				end
			end
		end
	end

	initial begin
		restart_machine(16'h0000);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_state();
		test_directed();
		test_random_programs();
		test_backpressure();
		test_steady_flow();
		in_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("tiny_accumulator_cpu_step_tb: clean");
		else
			$display("tiny_accumulator_cpu_step_tb: errors");
		$finish;
	end

endmodule

`default_nettype wire
